### src/mtm_pkg.sv
// Shared types and constants for the message timeout monitor.
package mtm_pkg;

    localparam int MAX_WINDOW   = 16;
    localparam int TIME_BITS    = 32;
    localparam int RING_AW      = $clog2(MAX_WINDOW);
    localparam int SUM_W        = TIME_BITS + RING_AW;
    localparam int WIN_W        = 5;
    localparam int PCT_W        = 10;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 32;
    localparam int PERCENT_BASE = 100;

    // divider: dividend covers avg * percent, two quotient bits per step
    localparam int DIV_W        = TIME_BITS + PCT_W;
    localparam int DIV_STEPS    = DIV_W / 2;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS + 1);
    localparam int DVSR_W       = 7;

    localparam logic [WIN_W-1:0]      WINDOW_RST  = WIN_W'(10);
    localparam logic [PCT_W-1:0]      PERCENT_RST = PCT_W'(25);

    localparam logic [CFG_IDX_W-1:0]  CFG_WINDOW  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0]  CFG_PERCENT = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0]  CFG_START   = CFG_IDX_W'(2);

    localparam logic OP_MESSAGE = 1'b0;
    localparam logic OP_CHECK   = 1'b1;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_ARRIVE,
        S_CHECK,
        S_DIV1_GO,
        S_DIV1_WAIT,
        S_MUL,
        S_DIV2_GO,
        S_DIV2_WAIT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic              start;
        logic [DIV_W-1:0]  dividend;
        logic [DVSR_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic               clear;
        logic               wr_en;
        logic [RING_AW-1:0] addr;
        logic [TIME_BITS-1:0] wr_data;
    } t_ring_ctl;

endpackage

### src/mtm_div.sv
// Shared iterative restoring divider, two quotient bits per cycle.
module mtm_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mtm_pkg::t_div_req i_req,
    output mtm_pkg::t_div_rsp o_rsp
);

    logic                          r_busy;
    logic [mtm_pkg::DIV_CNT_W-1:0] r_cnt;
    logic [mtm_pkg::DVSR_W-1:0]    r_rem;
    logic [mtm_pkg::DIV_W-1:0]     r_quo;
    logic [mtm_pkg::DVSR_W-1:0]    r_dvsr;

    logic [mtm_pkg::DVSR_W:0]      t1;
    logic [mtm_pkg::DVSR_W:0]      t2;
    logic [mtm_pkg::DVSR_W:0]      d1;
    logic [mtm_pkg::DVSR_W:0]      d2;
    logic                          q1;
    logic                          q2;
    logic [mtm_pkg::DVSR_W-1:0]    r1;
    logic [mtm_pkg::DVSR_W-1:0]    n_rem;
    logic [mtm_pkg::DIV_W-1:0]     n_quo;

    always_comb begin
        t1    = {r_rem, r_quo[mtm_pkg::DIV_W-1]};
        q1    = t1 >= {1'b0, r_dvsr};
        d1    = t1 - {1'b0, r_dvsr};
        r1    = q1 ? d1[mtm_pkg::DVSR_W-1:0] : t1[mtm_pkg::DVSR_W-1:0];
        t2    = {r1, r_quo[mtm_pkg::DIV_W-2]};
        q2    = t2 >= {1'b0, r_dvsr};
        d2    = t2 - {1'b0, r_dvsr};
        n_rem = q2 ? d2[mtm_pkg::DVSR_W-1:0] : t2[mtm_pkg::DVSR_W-1:0];
        n_quo = {r_quo[mtm_pkg::DIV_W-3:0], q1, q2};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_cnt  <= mtm_pkg::DIV_CNT_W'(mtm_pkg::DIV_STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - mtm_pkg::DIV_CNT_W'(1);
            if (r_cnt == mtm_pkg::DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo  <= i_req.dividend;
            r_rem  <= '0;
            r_dvsr <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done     = ~r_busy;
    assign o_rsp.quotient = r_quo;

endmodule

### src/mtm_ring.sv
// Interval ring: entries with valid bits, unwritten entries read as the base time.
module mtm_ring (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mtm_pkg::t_ring_ctl              i_ctl,
    input  logic [mtm_pkg::TIME_BITS-1:0]   i_base_time,
    output logic [mtm_pkg::TIME_BITS-1:0]   o_rd_data
);

    logic [mtm_pkg::TIME_BITS-1:0]  r_entry [mtm_pkg::MAX_WINDOW];
    logic [mtm_pkg::MAX_WINDOW-1:0] r_valid;
    logic [mtm_pkg::TIME_BITS-1:0]  r_rd_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_valid <= '0;
        end else if (i_ctl.wr_en) begin
            r_valid[i_ctl.addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_entry[i_ctl.addr] <= i_ctl.wr_data;
        end
    end

    // registered read; the address is held stable before the data is used
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_valid[i_ctl.addr] ? r_entry[i_ctl.addr] : i_base_time;
    end

    assign o_rd_data = r_rd_data;

endmodule

### src/message_timeout_monitor_top.sv
// Top level of the message timeout monitor: sequencer, state and handshakes.
//
// Watchdog for one message source. Each input transaction is a message arrival
// (opcode 0) or a timeout check (opcode 1) with a 32-bit wrapping timestamp,
// and each produces exactly one output transaction carrying the fault flag,
// the current average inter-message interval and the time since the last
// message. Arrivals push the interval into a ring of window_length entries;
// the first arrival seeds the average, later ones recompute it when the ring
// wraps. A check recomputes the average from the ring sum (once started) and
// flags a fault when elapsed > avg + avg * percent_over / 100. All divisions
// run on one shared divider that retires two quotient bits per cycle; the
// multiply by percent_over is registered in its own state. An arrival goes
// through the ring update and the result hand-off, an arrival that wraps the
// ring adds one divide, and a check runs two divides, or one before the
// first arrival. Input stall is high while a transaction is being worked on;
// a finished result waits in the output register, and the next input is
// accepted meanwhile. Writing window_length or the base time re-initializes
// all monitor state and passes through an init state (stall high) to rebuild
// the ring sum, held off while further register writes follow; reset also
// enters the init state. percent_over takes effect with no re-initialization.
// Configuration must be written only while idle; the block does not check it.
module message_timeout_monitor_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration write port
    input  logic                             i_cfg_we,
    input  logic [mtm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mtm_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input channel
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_opcode,
    input  logic [mtm_pkg::TIME_BITS-1:0]    i_time_value,
    // output channel
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_fault,
    output logic [mtm_pkg::TIME_BITS-1:0]    o_average_interval,
    output logic [mtm_pkg::TIME_BITS-1:0]    o_elapsed
);

    localparam int TB = mtm_pkg::TIME_BITS;

    // configuration registers
    logic [mtm_pkg::WIN_W-1:0]   r_window;
    logic [mtm_pkg::PCT_W-1:0]   r_percent;
    logic [TB-1:0]               r_start;

    // monitor state
    mtm_pkg::t_state             r_state;
    mtm_pkg::t_state             n_state;
    logic [TB-1:0]               r_last;
    logic                        r_started;
    logic [mtm_pkg::RING_AW-1:0] r_pos;
    logic [mtm_pkg::SUM_W-1:0]   r_sum;
    logic [TB-1:0]               r_avg;
    logic                        r_fault;

    // current transaction
    logic                        r_op;
    logic [TB-1:0]               r_now;
    logic [mtm_pkg::DIV_W-1:0]   r_prod;

    // output register
    logic                        r_out_valid;
    logic                        r_out_fault;
    logic [TB-1:0]               r_out_avg;
    logic [TB-1:0]               r_out_elapsed;

    // control and datapath nets
    logic                        in_accept;
    logic                        cfg_init;
    logic                        fin_load;
    logic [mtm_pkg::WIN_W-1:0]   w_eff;
    logic [mtm_pkg::WIN_W-1:0]   pos_inc;
    logic                        pos_wrap;
    logic [TB-1:0]               elapsed;
    logic [TB-1:0]               ring_rd;
    logic [TB+4:0]               threshold;
    mtm_pkg::t_div_req           div_req;
    mtm_pkg::t_div_rsp           div_rsp;
    mtm_pkg::t_ring_ctl          ring_ctl;

    mtm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    mtm_ring u_ring (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ring_ctl),
        .i_base_time  (r_start),
        .o_rd_data    (ring_rd)
    );

    // window of 0 acts as 1, anything above the ring depth as the full ring
    always_comb begin
        if (r_window == '0) begin
            w_eff = mtm_pkg::WIN_W'(1);
        end else if (r_window > mtm_pkg::WIN_W'(mtm_pkg::MAX_WINDOW)) begin
            w_eff = mtm_pkg::WIN_W'(mtm_pkg::MAX_WINDOW);
        end else begin
            w_eff = r_window;
        end
    end

    assign pos_inc   = {1'b0, r_pos} + mtm_pkg::WIN_W'(1);
    assign pos_wrap  = pos_inc == w_eff;
    assign elapsed   = r_now - r_last;
    // avg * pct / 100 stays below 2^36, so five guard bits cover the add
    assign threshold = {5'b0, r_avg} + div_rsp.quotient[TB+4:0];

    assign in_accept = i_in_valid && !o_in_stall;
    assign cfg_init  = i_cfg_we &&
                       (i_cfg_index == mtm_pkg::CFG_WINDOW ||
                        i_cfg_index == mtm_pkg::CFG_START);

    assign ring_ctl.clear   = cfg_init;
    assign ring_ctl.wr_en   = r_state == mtm_pkg::S_ARRIVE;
    assign ring_ctl.addr    = r_pos;
    assign ring_ctl.wr_data = elapsed;

    // sequencer: next state and strobes
    always_comb begin
        n_state          = r_state;
        o_in_stall       = 1'b1;
        fin_load         = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = mtm_pkg::DIV_W'(r_sum);
        div_req.divisor  = mtm_pkg::DVSR_W'(w_eff);
        case (r_state)
            mtm_pkg::S_INIT: begin
                // the ring sum is rebuilt on a cycle free of register writes
                n_state = i_cfg_we ? mtm_pkg::S_INIT : mtm_pkg::S_IDLE;
            end
            mtm_pkg::S_IDLE: begin
                o_in_stall = 1'b0;
                if (in_accept) begin
                    n_state = (i_opcode == mtm_pkg::OP_CHECK) ? mtm_pkg::S_CHECK
                                                              : mtm_pkg::S_ARRIVE;
                end
            end
            mtm_pkg::S_ARRIVE: begin
                n_state = (r_started && pos_wrap) ? mtm_pkg::S_DIV1_GO : mtm_pkg::S_FIN;
            end
            mtm_pkg::S_CHECK: begin
                n_state = r_started ? mtm_pkg::S_DIV1_GO : mtm_pkg::S_MUL;
            end
            mtm_pkg::S_DIV1_GO: begin
                div_req.start = 1'b1;
                n_state       = mtm_pkg::S_DIV1_WAIT;
            end
            mtm_pkg::S_DIV1_WAIT: begin
                if (div_rsp.done) begin
                    n_state = (r_op == mtm_pkg::OP_CHECK) ? mtm_pkg::S_MUL : mtm_pkg::S_FIN;
                end
            end
            mtm_pkg::S_MUL: begin
                n_state = mtm_pkg::S_DIV2_GO;
            end
            mtm_pkg::S_DIV2_GO: begin
                div_req.start    = 1'b1;
                div_req.dividend = r_prod;
                div_req.divisor  = mtm_pkg::DVSR_W'(mtm_pkg::PERCENT_BASE);
                n_state          = mtm_pkg::S_DIV2_WAIT;
            end
            mtm_pkg::S_DIV2_WAIT: begin
                div_req.dividend = r_prod;
                div_req.divisor  = mtm_pkg::DVSR_W'(mtm_pkg::PERCENT_BASE);
                if (div_rsp.done) begin
                    n_state = mtm_pkg::S_FIN;
                end
            end
            mtm_pkg::S_FIN: begin
                // hand off once the output register is free or being emptied
                if (!r_out_valid || !i_out_stall) begin
                    fin_load = 1'b1;
                    n_state  = mtm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = mtm_pkg::S_INIT;
            end
        endcase
        if (cfg_init) begin
            n_state = mtm_pkg::S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mtm_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    // configuration and monitor state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window  <= mtm_pkg::WINDOW_RST;
            r_percent <= mtm_pkg::PERCENT_RST;
            r_start   <= '0;
            r_last    <= '0;
            r_started <= 1'b0;
            r_pos     <= '0;
            r_sum     <= '0;
            r_avg     <= '0;
            r_fault   <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                mtm_pkg::CFG_WINDOW: begin
                    r_window <= i_cfg_data[mtm_pkg::WIN_W-1:0];
                    r_last   <= r_start;
                end
                mtm_pkg::CFG_PERCENT: begin
                    r_percent <= i_cfg_data[mtm_pkg::PCT_W-1:0];
                end
                mtm_pkg::CFG_START: begin
                    r_start <= i_cfg_data[TB-1:0];
                    r_last  <= i_cfg_data[TB-1:0];
                end
                default: begin
                end
            endcase
            if (cfg_init) begin
                r_started <= 1'b0;
                r_pos     <= '0;
                r_avg     <= '0;
                r_fault   <= 1'b0;
            end
        end else begin
            case (r_state)
                mtm_pkg::S_INIT: begin
                    // every ring entry holds the base time after init
                    r_sum <= mtm_pkg::SUM_W'(w_eff) * mtm_pkg::SUM_W'(r_start);
                end
                mtm_pkg::S_ARRIVE: begin
                    r_sum  <= r_sum - mtm_pkg::SUM_W'(ring_rd) + mtm_pkg::SUM_W'(elapsed);
                    r_last <= r_now;
                    r_pos  <= pos_wrap ? '0 : pos_inc[mtm_pkg::RING_AW-1:0];
                    if (!r_started) begin
                        r_avg     <= elapsed;
                        r_started <= 1'b1;
                    end
                end
                mtm_pkg::S_DIV1_WAIT: begin
                    if (div_rsp.done) begin
                        r_avg <= div_rsp.quotient[TB-1:0];
                    end
                end
                mtm_pkg::S_DIV2_WAIT: begin
                    if (div_rsp.done) begin
                        r_fault <= {5'b0, elapsed} > threshold;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // transaction payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op  <= i_opcode;
            r_now <= i_time_value;
        end
        if (r_state == mtm_pkg::S_MUL) begin
            r_prod <= {{mtm_pkg::PCT_W{1'b0}}, r_avg} *
                      {{TB{1'b0}}, r_percent};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fin_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fin_load) begin
            r_out_fault   <= r_fault;
            r_out_avg     <= r_avg;
            r_out_elapsed <= elapsed;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_fault            = r_out_fault;
    assign o_average_interval = r_out_avg;
    assign o_elapsed          = r_out_elapsed;

endmodule
